// File: rtl/glhfs_pkg.sv
`default_nettype none
package glhfs_pkg;

  localparam int unsigned TEMP_W       = 16;
  localparam int unsigned DEPTH_W      = 20;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned LAYERS_CFG_W = 5;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 20'hFFFFF;

  localparam logic OPCODE_TICK = 1'b0;
  localparam logic OPCODE_LOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_GAIN        = 3'd0,
    REG_ABOVE_FACTOR     = 3'd1,
    REG_BELOW_FACTOR     = 3'd2,
    REG_BOTTOM_TEMP      = 3'd3,
    REG_LAYER_THICKNESS  = 3'd4,
    REG_FREEZING_TEMP    = 3'd5,
    REG_LAYERS_IN_USE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] step_gain;
    logic        [15:0] above_factor;
    logic        [15:0] below_factor;
    logic signed [15:0] bottom_temperature;
    logic        [15:0] layer_span;
    logic signed [15:0] freeze_level;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_LOAD_WR,
    OP_RD_ZERO,
    OP_T0,
    OP_RD_IDX,
    OP_SCAN_HI,
    OP_NO_WARM,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_RA,
    OP_RB,
    OP_RGL,
    OP_RGH,
    OP_RUP,
    OP_CAPTURE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic t0_below;
    logic hi_warm;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/glhfs_cfg.sv
`default_nettype none
module glhfs_cfg #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [glhfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [glhfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output glhfs_pkg::cfg_t                            cfg,
  output logic [$clog2(MAX_LAYERS+1)-1:0]            layers
);

  localparam int unsigned NW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned CW = (NW > glhfs_pkg::LAYERS_CFG_W) ? NW : glhfs_pkg::LAYERS_CFG_W;

  logic [glhfs_pkg::LAYERS_CFG_W-1:0] layers_in_use;
  logic [CW-1:0]                      lay_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_gain            <= 16'd6554;
      cfg.above_factor         <= 16'd16384;
      cfg.below_factor         <= 16'd16384;
      cfg.bottom_temperature   <= 16'sd2560;
      cfg.layer_span           <= 16'd256;
      cfg.freeze_level         <= 16'sd0;
      layers_in_use            <= 5'd8;
    end else if (cfg_write) begin
      case (glhfs_pkg::reg_idx_t'(cfg_index))
        glhfs_pkg::REG_STEP_GAIN:       cfg.step_gain <= cfg_data;
        glhfs_pkg::REG_ABOVE_FACTOR:    cfg.above_factor <= cfg_data;
        glhfs_pkg::REG_BELOW_FACTOR:    cfg.below_factor <= cfg_data;
        glhfs_pkg::REG_BOTTOM_TEMP:     cfg.bottom_temperature <= $signed(cfg_data);
        glhfs_pkg::REG_LAYER_THICKNESS: cfg.layer_span <= cfg_data;
        glhfs_pkg::REG_FREEZING_TEMP:   cfg.freeze_level <= $signed(cfg_data);
        glhfs_pkg::REG_LAYERS_IN_USE:   layers_in_use <= cfg_data[glhfs_pkg::LAYERS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // active layer count clamped to 2..MAX_LAYERS
  assign lay_ext = CW'(layers_in_use);

  always_comb begin
    if (lay_ext < CW'(2)) begin
      layers = NW'(2);
    end else if (lay_ext > CW'(MAX_LAYERS)) begin
      layers = NW'(MAX_LAYERS);
    end else begin
      layers = NW'(lay_ext);
    end
  end

endmodule
`default_nettype wire

// File: rtl/glhfs_ctrl.sv
`default_nettype none
module glhfs_ctrl #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            opcode,
  input  wire logic [$clog2(MAX_LAYERS+1)-1:0] layers,
  input  wire glhfs_pkg::dp_stat_t             stat,
  output logic                                 busy,
  output logic                                 done,
  output glhfs_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(MAX_LAYERS+1)-1:0]      idx
);

  localparam int unsigned NW = $clog2(MAX_LAYERS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_TOP_RD,
    S_TOP_W,
    S_T0_RD,
    S_T0_W,
    S_SCAN_RD,
    S_SCAN_W,
    S_DIV,
    S_DIV_END,
    S_RA,
    S_RB,
    S_RGL,
    S_RGH,
    S_RUP
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic       last;

  assign busy = (state != S_IDLE);
  assign last = (idx == layers - NW'(1));

  always_comb begin
    cmd.last = last;
    case (state)
      S_IDLE:    cmd.op = start ? glhfs_pkg::OP_TAKE : glhfs_pkg::OP_NONE;
      S_LOAD:    cmd.op = glhfs_pkg::OP_LOAD_WR;
      S_TOP_RD:  cmd.op = glhfs_pkg::OP_RD_ZERO;
      S_TOP_W:   cmd.op = glhfs_pkg::OP_CAPTURE;
      S_T0_RD:   cmd.op = glhfs_pkg::OP_RD_ZERO;
      S_T0_W:    cmd.op = glhfs_pkg::OP_T0;
      S_SCAN_RD: cmd.op = (idx == layers) ? glhfs_pkg::OP_NO_WARM : glhfs_pkg::OP_RD_IDX;
      S_SCAN_W:  cmd.op = glhfs_pkg::OP_SCAN_HI;
      S_DIV:     cmd.op = glhfs_pkg::OP_DIV_STEP;
      S_DIV_END: cmd.op = glhfs_pkg::OP_DIV_END;
      S_RA:      cmd.op = glhfs_pkg::OP_RA;
      S_RB:      cmd.op = glhfs_pkg::OP_RB;
      S_RGL:     cmd.op = glhfs_pkg::OP_RGL;
      S_RGH:     cmd.op = glhfs_pkg::OP_RGH;
      S_RUP:     cmd.op = glhfs_pkg::OP_RUP;
      default:   cmd.op = glhfs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= (opcode == glhfs_pkg::OPCODE_LOAD) ? S_LOAD : S_T0_RD;
          end
        end
        S_LOAD:   state <= S_TOP_RD;
        S_TOP_RD: state <= S_TOP_W;
        S_TOP_W: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_T0_RD:  state <= S_T0_W;
        S_T0_W: begin
          if (stat.t0_below) begin
            idx   <= NW'(1);
            state <= S_SCAN_RD;
          end else begin
            idx   <= '0;
            state <= S_RA;
          end
        end
        S_SCAN_RD: begin
          if (idx == layers) begin
            idx   <= '0;
            state <= S_RA;
          end else begin
            state <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          if (stat.hi_warm) begin
            step  <= '0;
            state <= S_DIV;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_DIV: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          idx   <= '0;
          state <= S_RA;
        end
        S_RA:  state <= S_RB;
        S_RB:  state <= S_RGL;
        S_RGL: state <= S_RGH;
        S_RGH: state <= S_RUP;
        S_RUP: begin
          if (last) begin
            state <= S_TOP_RD;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_RA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/glhfs_dp.sv
`default_nettype none
module glhfs_dp #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire glhfs_pkg::dp_cmd_t                  cmd,
  input  wire logic [$clog2(MAX_LAYERS+1)-1:0]     idx,
  input  wire glhfs_pkg::cfg_t                     cfg,
  input  wire logic [$clog2(MAX_LAYERS+1)-1:0]     layers,
  input  wire logic signed [15:0]                  air_temperature,
  input  wire logic [3:0]                          layer_index,
  input  wire logic signed [15:0]                  layer_value,
  output glhfs_pkg::dp_stat_t                      stat,
  output logic                                     frozen,
  output logic [glhfs_pkg::DEPTH_W-1:0]            ice_depth,
  output logic signed [15:0]                       top_layer_temperature
);

  localparam int unsigned NW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned AW = $clog2(MAX_LAYERS);
  localparam int unsigned BW = 16 + NW;
  localparam int unsigned DW = (BW + 1 > 21) ? BW + 1 : 21;

  localparam logic signed [22:0] UPD_MAX = 23'sd32767;
  localparam logic signed [22:0] UPD_MIN = -23'sd32768;

  // layer store with per-entry valid bits, unwritten entries read as zero
  logic signed [15:0]   mem [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] valid;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic signed [15:0]   rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [15:0]   wr_data;

  // latched item
  logic signed [15:0] air_r;
  logic [3:0]         index_r;
  logic signed [15:0] value_r;
  logic               load_ok;

  // frost scan and divider
  logic               frozen_w;
  logic [19:0]        depth_w;
  logic signed [15:0] prev;
  logic [BW-1:0]      base;
  logic [15:0]        rem;
  logic [15:0]        den;
  logic [15:0]        quo;
  logic signed [16:0] fdiff;
  logic signed [16:0] hdiff;
  logic [31:0]        num;
  logic [NW-1:0]      km1;
  logic [BW-1:0]      base_next;
  logic [BW-1:0]      full_depth;
  logic [16:0]        trial;
  logic [DW-1:0]      dsum;
  logic [DW-1:0]      dfull;

  // relaxation
  logic signed [15:0] up;
  logic signed [15:0] cur;
  logic signed [15:0] down;
  logic signed [15:0] down_r;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] prod_a;
  logic signed [34:0] acc;
  logic signed [34:0] acc_next;
  logic [31:0]        plo;
  logic [31:0]        plo_next;
  logic signed [35:0] phi;
  logic signed [35:0] phi_next;
  logic signed [52:0] gsum;
  logic signed [21:0] delta;
  logic signed [22:0] upd;
  logic signed [15:0] upd_sat;
  logic [NW-1:0]      idx_inc;

  assign stat.t0_below = (rd_data < cfg.freeze_level);
  assign stat.hi_warm  = (rd_data > cfg.freeze_level);

  assign load_ok = (32'(index_r) < MAX_LAYERS);
  assign idx_inc = idx + NW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = upd_sat;
    case (cmd.op)
      glhfs_pkg::OP_RD_ZERO: rd_en = 1'b1;
      glhfs_pkg::OP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx[AW-1:0];
      end
      glhfs_pkg::OP_RA: begin
        // fetch the old value of the layer below
        rd_en   = 1'b1;
        rd_addr = idx_inc[AW-1:0];
      end
      glhfs_pkg::OP_LOAD_WR: begin
        wr_en   = load_ok;
        wr_addr = AW'(index_r);
        wr_data = value_r;
      end
      glhfs_pkg::OP_RUP: wr_en = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // frost depth arithmetic
  assign fdiff      = 17'(cfg.freeze_level) - 17'(prev);
  assign hdiff      = 17'(rd_data) - 17'(prev);
  assign num        = {16'd0, cfg.layer_span} * {16'd0, fdiff[15:0]};
  assign km1        = idx - NW'(1);
  assign base_next  = BW'(cfg.layer_span) * BW'(km1);
  assign full_depth = BW'(cfg.layer_span) * BW'(layers);
  assign trial      = {rem, quo[15]};
  assign dsum       = DW'(base) + DW'(quo);
  assign dfull      = DW'(full_depth);

  // relaxation arithmetic
  assign down     = cmd.last ? cfg.bottom_temperature : rd_data;
  assign mul_a    = 33'($signed({1'b0, cfg.above_factor})) * 33'(up);
  assign mul_b    = 33'($signed({1'b0, cfg.below_factor})) * 33'(down);
  assign acc_next = 35'(prod_a) + 35'(mul_b) - (35'(cur) <<< 15);
  assign plo_next = {16'd0, acc[15:0]} * {16'd0, cfg.step_gain};
  assign phi_next = 36'($signed(acc[34:16])) * 36'($signed({1'b0, cfg.step_gain}));
  assign gsum     = (53'(phi) <<< 16) + $signed({21'd0, plo});
  assign delta    = 22'(gsum >>> 31);
  assign upd      = 23'(cur) + 23'(delta);

  always_comb begin
    if (upd > UPD_MAX) begin
      upd_sat = 16'sh7FFF;
    end else if (upd < UPD_MIN) begin
      upd_sat = 16'sh8000;
    end else begin
      upd_sat = upd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      glhfs_pkg::OP_TAKE: begin
        air_r    <= air_temperature;
        index_r  <= layer_index;
        value_r  <= layer_value;
        frozen_w <= 1'b0;
        depth_w  <= '0;
      end
      glhfs_pkg::OP_T0: begin
        frozen_w <= stat.t0_below;
        cur      <= rd_data;
        prev     <= rd_data;
        up       <= air_r;
      end
      glhfs_pkg::OP_SCAN_HI: begin
        if (stat.hi_warm) begin
          base <= base_next;
          den  <= hdiff[15:0];
          rem  <= num[31:16];
          quo  <= num[15:0];
        end else begin
          prev <= rd_data;
        end
      end
      glhfs_pkg::OP_NO_WARM: begin
        depth_w <= (dfull > DW'(glhfs_pkg::DEPTH_MAX)) ? glhfs_pkg::DEPTH_MAX
                                                        : dfull[19:0];
      end
      glhfs_pkg::OP_DIV_STEP: begin
        if (trial >= {1'b0, den}) begin
          rem <= 16'(trial - {1'b0, den});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b0};
        end
      end
      glhfs_pkg::OP_DIV_END: begin
        depth_w <= (dsum > DW'(glhfs_pkg::DEPTH_MAX)) ? glhfs_pkg::DEPTH_MAX
                                                       : dsum[19:0];
      end
      glhfs_pkg::OP_RA: prod_a <= mul_a;
      glhfs_pkg::OP_RB: begin
        acc    <= acc_next;
        down_r <= down;
      end
      glhfs_pkg::OP_RGL: plo <= plo_next;
      glhfs_pkg::OP_RGH: phi <= phi_next;
      glhfs_pkg::OP_RUP: begin
        // updated layer becomes the one above, old layer below becomes current
        up  <= upd_sat;
        cur <= down_r;
      end
      glhfs_pkg::OP_CAPTURE: begin
        frozen                <= frozen_w;
        ice_depth             <= depth_w;
        top_layer_temperature <= rd_data;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ground_layer_heat_and_frost_step_unit.sv
`default_nettype none
// Ground layer heat and frost step. Pulse start while busy is low to hand in one word: a load
// (opcode 1) writes one layer, a tick (opcode 0) measures frost depth and then relaxes all
// active layers in place. Every word returns one result word, shown on frozen, ice_depth and
// top_layer_temperature for the single cycle in which done is high; the result cannot be
// stalled, so it must be taken in that cycle. A new word may be started in the done cycle.
// A load writes the layer, then reads back the top layer for the result. A tick reads the
// top layer; when it is below freezing, the frost scan reads the layer store one layer at a
// time, down to the first layer above freezing, and the depth interpolation is a 16-step
// radix-2 divider. Each layer update then runs through the states RA, RB, RGL, RGH and RUP
// of multiply, accumulate and scale, and the top layer is read again for the result.
// Configuration writes are taken on any cycle with cfg_write high and must only happen while
// the block is idle.
module ground_layer_heat_and_frost_step_unit #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               opcode,
  input  wire logic signed [15:0]                 air_temperature,
  input  wire logic [3:0]                         layer_index,
  input  wire logic signed [15:0]                 layer_value,
  output logic                                    done,
  output logic                                    frozen,
  output logic [19:0]                             ice_depth,
  output logic signed [15:0]                      top_layer_temperature,
  input  wire logic                               cfg_write,
  input  wire logic [glhfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [glhfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned NW = $clog2(MAX_LAYERS + 1);

  glhfs_pkg::cfg_t     cfg;
  glhfs_pkg::dp_cmd_t  cmd;
  glhfs_pkg::dp_stat_t stat;
  logic [NW-1:0]       layers;
  logic [NW-1:0]       idx;

  glhfs_cfg #(
    .MAX_LAYERS(MAX_LAYERS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .layers    (layers)
  );

  glhfs_ctrl #(
    .MAX_LAYERS(MAX_LAYERS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .layers (layers),
    .stat   (stat),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .idx    (idx)
  );

  glhfs_dp #(
    .MAX_LAYERS(MAX_LAYERS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .idx                   (idx),
    .cfg                   (cfg),
    .layers                (layers),
    .air_temperature       (air_temperature),
    .layer_index           (layer_index),
    .layer_value           (layer_value),
    .stat                  (stat),
    .frozen                (frozen),
    .ice_depth             (ice_depth),
    .top_layer_temperature (top_layer_temperature)
  );

endmodule
`default_nettype wire
